@@ rtl/assert_macros.svh @@
// Assertion macros shared by the list engine RTL.
// No dependencies; included by indexed_list_engine_core, which carries concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ rtl/ile_pkg.sv @@
// Shared types and constants of the indexed list engine.
// No dependencies; used by the interfaces, the cell and the top level.
package ile_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int POS_W  = 5;
  localparam int ST_W   = 2;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_NEXT   = 3'd3,
    OP_REWIND = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // Per-cell control for one cycle.
  typedef struct packed {
    logic load;        // take the inserted value
    logic take_left;   // shift up: take the lower neighbour's word
    logic take_right;  // shift down: take the upper neighbour's word
    logic rd_sel;      // drive the word onto the read bus
  } cell_ctl_t;

endpackage

@@ rtl/ile_in_if.sv @@
// Request channel of the indexed list engine: valid/ready with payload.
// Depends on ile_pkg for the field widths.
interface ile_in_if;
  logic                              valid;
  logic                              ready;
  logic [ile_pkg::OP_W-1:0]          operation;
  logic [ile_pkg::POS_W-1:0]         position;
  logic signed [ile_pkg::DATA_W-1:0] item_value;

  modport source (output valid, operation, position, item_value, input ready);
  modport sink   (input valid, operation, position, item_value, output ready);
endinterface

@@ rtl/ile_out_if.sv @@
// Result channel of the indexed list engine: valid/ready with payload.
// Depends on ile_pkg for the field widths.
interface ile_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [ile_pkg::DATA_W-1:0] read_value;
  logic [ile_pkg::ST_W-1:0]          status;
  logic [ile_pkg::CNT_OUT_W-1:0]     entry_count;
  logic                              more_items;

  modport source (output valid, read_value, status, entry_count, more_items, input ready);
  modport sink   (input valid, read_value, status, entry_count, more_items, output ready);
endinterface

@@ rtl/ile_cell.sv @@
// One list cell: holds a single entry and trades it with its neighbours.
// Depends on ile_pkg for the control struct and data width.
module ile_cell (
  input  logic                          clk,
  input  ile_pkg::cell_ctl_t            ctl,
  input  logic [ile_pkg::DATA_W-1:0]    ins_val,
  input  logic [ile_pkg::DATA_W-1:0]    left_val,
  input  logic [ile_pkg::DATA_W-1:0]    right_val,
  output logic [ile_pkg::DATA_W-1:0]    val,
  output logic [ile_pkg::DATA_W-1:0]    rd_val
);

  logic [ile_pkg::DATA_W-1:0] value_r;

  // The word is loaded, shifted in from a neighbour, or held.
  always_ff @(posedge clk) begin
    priority if (ctl.load) begin
      value_r <= ins_val;
    end else if (ctl.take_left) begin
      value_r <= left_val;
    end else if (ctl.take_right) begin
      value_r <= right_val;
    end else begin
      value_r <= value_r;
    end
  end

  // Only the selected cell puts its word on the OR-combined read bus.
  assign val    = value_r;
  assign rd_val = ctl.rd_sel ? value_r : '0;

endmodule

@@ rtl/indexed_list_engine_core.sv @@
// Top level of the indexed list engine: control, cell row and result register.
// Depends on ile_pkg, ile_in_if, ile_out_if, ile_cell and assert_macros.svh.
//
// Usage:
//   in_req carries one request per handshake: operation, position and
//   item_value. out_rsp returns exactly one result per request, in order:
//   read_value, status, entry_count and more_items.
//   The list is a row of DEPTH cells. Insert and remove move every affected
//   cell one place in the same cycle. The result is registered: a request
//   accepted at an edge has its result valid after that edge. Throughput is
//   one request per cycle while the receiver takes each result; the single
//   result register stays full while the receiver stalls.
//   in_req.ready is high when the result register is empty or being drained,
//   so a stall on out_rsp holds the result and blocks new requests until
//   it is taken.
//   Reset (rst_n low, synchronous) empties the list, rewinds the read
//   cursor and drops any pending result. Cell contents are not cleared;
//   only entries below the count are ever read.
`include "assert_macros.svh"
module indexed_list_engine_core #(
  parameter int DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ile_in_if.sink    in_req,
  ile_out_if.source out_rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] cursor_r, cursor_nxt;

  logic                          out_valid_r;
  logic [ile_pkg::DATA_W-1:0]    out_read_value_r;
  logic [ile_pkg::ST_W-1:0]      out_status_r;
  logic [ile_pkg::CNT_OUT_W-1:0] out_entry_count_r;
  logic                          out_more_items_r;

  logic             accept;
  logic [CMP_W-1:0] pos_ext, count_ext, cursor_ext, rd_addr, count_nxt_ext;
  logic             do_ins, do_rem, rd_ok;
  ile_pkg::status_t status;

  logic [ile_pkg::DATA_W-1:0] cell_val  [DEPTH];
  logic [ile_pkg::DATA_W-1:0] cell_rd   [DEPTH];
  logic [ile_pkg::DATA_W-1:0] left_in   [DEPTH];
  logic [ile_pkg::DATA_W-1:0] right_in  [DEPTH];
  ile_pkg::cell_ctl_t         cell_ctl  [DEPTH];
  logic [ile_pkg::DATA_W-1:0] rd_bus;

  // Handshake: a new request enters whenever the result register can move on.
  assign in_req.ready = !out_valid_r || out_rsp.ready;
  assign accept       = in_req.valid && in_req.ready;

  assign pos_ext    = CMP_W'(in_req.position);
  assign count_ext  = CMP_W'(count_r);
  assign cursor_ext = CMP_W'(cursor_r);

  // Decode of the request against the current count and cursor.
  always_comb begin
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    rd_ok   = 1'b0;
    rd_addr = pos_ext;
    status  = ile_pkg::ST_OK;
    unique case (in_req.operation)
      ile_pkg::OP_INSERT: begin
        if (pos_ext > count_ext) begin
          status = ile_pkg::ST_RANGE;
        end else if (count_r >= DEPTH_C) begin
          status = ile_pkg::ST_FULL;
        end else begin
          do_ins = accept;
        end
      end
      ile_pkg::OP_REMOVE: begin
        if (pos_ext >= count_ext) begin
          status = ile_pkg::ST_RANGE;
        end else begin
          do_rem = accept;
        end
      end
      ile_pkg::OP_READ: begin
        if (pos_ext >= count_ext) begin
          status = ile_pkg::ST_RANGE;
        end else begin
          rd_ok = 1'b1;
        end
      end
      ile_pkg::OP_NEXT: begin
        rd_addr = cursor_ext;
        if (cursor_r >= count_r) begin
          status = ile_pkg::ST_EMPTY;
        end else begin
          rd_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Count and cursor for the next cycle.
  always_comb begin
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    if (accept) begin
      if (do_ins) begin
        count_nxt = count_r + 1'b1;
      end else if (do_rem) begin
        count_nxt = count_r - 1'b1;
      end
      if (in_req.operation == ile_pkg::OP_NEXT && rd_ok) begin
        cursor_nxt = cursor_r + 1'b1;
      end else if (in_req.operation == ile_pkg::OP_REWIND) begin
        cursor_nxt = '0;
      end
    end
  end

  assign count_nxt_ext = CMP_W'(count_nxt);

  // The cell row, with neighbour links and per-cell control.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMP_W-1:0] IDX = CMP_W'(i);

    if (i == 0) begin : g_first
      assign left_in[i] = '0;
    end else begin : g_inner_l
      assign left_in[i] = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in[i] = '0;
    end else begin : g_inner_r
      assign right_in[i] = cell_val[i+1];
    end

    assign cell_ctl[i].load       = do_ins && (pos_ext == IDX);
    assign cell_ctl[i].take_left  = do_ins && (IDX > pos_ext);
    assign cell_ctl[i].take_right = do_rem && (IDX >= pos_ext);
    assign cell_ctl[i].rd_sel     = rd_ok && (rd_addr == IDX);

    ile_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .ins_val   (in_req.item_value),
      .left_val  (left_in[i]),
      .right_val (right_in[i]),
      .val       (cell_val[i]),
      .rd_val    (cell_rd[i])
    );
  end

  // Read bus: at most one cell drives a non-zero word.
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      cursor_r <= cursor_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register, loaded with each accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_read_value_r  <= rd_bus;
      out_status_r      <= status;
      out_entry_count_r <= count_nxt_ext[ile_pkg::CNT_OUT_W-1:0];
      out_more_items_r  <= (cursor_nxt < count_nxt);
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.read_value  = out_read_value_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.entry_count = out_entry_count_r;
  assign out_rsp.more_items  = out_more_items_r;

  // Checks on the list bookkeeping.
  `ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= DEPTH_C, "count exceeds depth")
  `ASSERT_NEXT(a_ins_grows, clk, rst_n, do_ins, count_r == $past(count_r) + 1'b1, "insert lost")
  `ASSERT_NEXT(a_rem_shrinks, clk, rst_n, do_rem, count_r == $past(count_r) - 1'b1, "remove lost")
  `ASSERT_IMPL(a_one_reader, clk, rst_n, 1'b1, !(do_ins && do_rem), "insert and remove together")

endmodule
